/* rtl/stl_pkg.sv */
`timescale 1ns / 1ps
package stl_pkg;

  typedef enum logic [2:0] {
    MODE_BETWEEN,
    MODE_SLASH,
    MODE_LINE_CMT,
    MODE_BLOCK_CMT,
    MODE_WORD,
    MODE_QUOTE,
    MODE_HALTED
  } mode_t;

  localparam logic [2:0] EV_CHAR       = 3'd0;
  localparam logic [2:0] EV_END        = 3'd1;
  localparam logic [2:0] EV_OPEN_CMT   = 3'd2;
  localparam logic [2:0] EV_OPEN_QUOTE = 3'd3;
  localparam logic [2:0] EV_TOO_LONG   = 3'd4;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_LBRACE  = 8'h7b;
  localparam logic [7:0] CH_RBRACE  = 8'h7d;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;

  localparam int LINE_W = 20;
  localparam int COL_W  = 16;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [COL_W-1:0]  COL_MAX  = '1;

  // up to four results per text byte
  localparam int SLOTS       = 4;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [2:0] ev;
    logic [7:0] ch;
    logic       new_pos;  // 1: position is the current byte, 0: the stored token start
  } slot_t;

  typedef struct packed {
    slot_t [SLOTS-1:0]  slots;
    logic [CNT_W-1:0]   cnt;
    logic               q;
    logic [LINE_W-1:0]  old_line;
    logic [COL_W-1:0]   old_col;
    logic [LINE_W-1:0]  cur_line;
    logic [COL_W-1:0]   cur_col;
  } bundle_t;

endpackage

/* rtl/stl_front.sv */
`timescale 1ns / 1ps
module stl_front import stl_pkg::*; #(
  parameter int TOKEN_BUFFER_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_value,
  input  logic       last_of_text,
  input  logic       full,
  output logic       push,
  output bundle_t    bundle
);

  localparam int LEN_W = $clog2(TOKEN_BUFFER_BYTES);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(TOKEN_BUFFER_BYTES - 1);

  mode_t             mode, mode_next;
  logic              star_seen, star_next;
  logic [LEN_W-1:0]  token_length, len_next;
  logic [LINE_W-1:0] line_number, line_next, start_line, start_line_next;
  logic [COL_W-1:0]  column_number, col_next, start_column, start_col_next;

  logic              marked, do_word, is_brace, accept;
  logic [CNT_W-1:0]  cnt;
  slot_t [SLOTS-1:0] slots;

  assign is_brace = (byte_value == CH_LBRACE) || (byte_value == CH_RBRACE);
  assign accept   = in_valid && !full;
  assign in_stall = full;
  assign push     = accept && (cnt != '0);

  always_comb begin
    mode_next = mode;
    star_next = star_seen;
    len_next  = token_length;
    marked    = 1'b0;
    do_word   = 1'b0;
    cnt       = '0;
    slots     = '0;

    unique case (mode)
      MODE_BETWEEN: begin
        if (byte_value > CH_SPACE) begin
          marked   = 1'b1;
          len_next = '0;
          if (byte_value == CH_SLASH) begin
            mode_next = MODE_SLASH;
          end else if (is_brace) begin
            slots[0] = '{ev: EV_CHAR, ch: byte_value, new_pos: 1'b1};
            slots[1] = '{ev: EV_END, ch: 8'h00, new_pos: 1'b1};
            cnt      = CNT_W'(2);
          end else if (byte_value == CH_QUOTE) begin
            mode_next = MODE_QUOTE;
          end else begin
            mode_next = MODE_WORD;
            do_word   = 1'b1;
          end
        end
      end
      MODE_SLASH: begin
        if (byte_value == CH_SLASH) begin
          mode_next = MODE_LINE_CMT;
        end else if (byte_value == CH_STAR) begin
          mode_next = MODE_BLOCK_CMT;
          star_next = 1'b0;
        end else begin
          // waiting slash becomes the first byte of a word
          mode_next = MODE_WORD;
          len_next  = LEN_W'(1);
          slots[0]  = '{ev: EV_CHAR, ch: CH_SLASH, new_pos: 1'b0};
          cnt       = CNT_W'(1);
          do_word   = 1'b1;
        end
      end
      MODE_LINE_CMT: begin
        if (byte_value == CH_NEWLINE) mode_next = MODE_BETWEEN;
      end
      MODE_BLOCK_CMT: begin
        if (star_seen && byte_value == CH_SLASH) begin
          mode_next = MODE_BETWEEN;
          star_next = 1'b0;
        end else begin
          star_next = (byte_value == CH_STAR);
        end
      end
      MODE_WORD: begin
        do_word = 1'b1;
      end
      MODE_QUOTE: begin
        if (byte_value == CH_QUOTE) begin
          slots[0]  = '{ev: EV_END, ch: 8'h00, new_pos: 1'b0};
          cnt       = CNT_W'(1);
          mode_next = MODE_BETWEEN;
        end else if (len_next == LEN_LAST) begin
          slots[0]  = '{ev: EV_TOO_LONG, ch: 8'h00, new_pos: 1'b0};
          cnt       = CNT_W'(1);
          mode_next = MODE_HALTED;
        end else begin
          len_next = len_next + LEN_W'(1);
          slots[0] = '{ev: EV_CHAR, ch: byte_value, new_pos: 1'b0};
          cnt      = CNT_W'(1);
        end
      end
      MODE_HALTED: begin
      end
      default: begin
      end
    endcase

    if (do_word) begin
      if (byte_value <= CH_SPACE) begin
        slots[cnt[IDX_W-1:0]] = '{ev: EV_END, ch: 8'h00, new_pos: marked};
        cnt       = cnt + CNT_W'(1);
        mode_next = MODE_BETWEEN;
      end else if (is_brace) begin
        // word ends, brace follows as its own token
        slots[cnt[IDX_W-1:0]] = '{ev: EV_END, ch: 8'h00, new_pos: marked};
        cnt       = cnt + CNT_W'(1);
        mode_next = MODE_BETWEEN;
        marked    = 1'b1;
        slots[cnt[IDX_W-1:0]] = '{ev: EV_CHAR, ch: byte_value, new_pos: 1'b1};
        cnt       = cnt + CNT_W'(1);
        slots[cnt[IDX_W-1:0]] = '{ev: EV_END, ch: 8'h00, new_pos: 1'b1};
        cnt       = cnt + CNT_W'(1);
      end else if (len_next == LEN_LAST) begin
        slots[cnt[IDX_W-1:0]] = '{ev: EV_TOO_LONG, ch: 8'h00, new_pos: marked};
        cnt       = cnt + CNT_W'(1);
        mode_next = MODE_HALTED;
      end else begin
        len_next = len_next + LEN_W'(1);
        slots[cnt[IDX_W-1:0]] = '{ev: EV_CHAR, ch: byte_value, new_pos: marked};
        cnt      = cnt + CNT_W'(1);
      end
    end

    if (last_of_text) begin
      unique case (mode_next)
        MODE_SLASH: begin
          slots[cnt[IDX_W-1:0]] = '{ev: EV_CHAR, ch: CH_SLASH, new_pos: marked};
          cnt = cnt + CNT_W'(1);
          slots[cnt[IDX_W-1:0]] = '{ev: EV_END, ch: 8'h00, new_pos: marked};
          cnt = cnt + CNT_W'(1);
        end
        MODE_WORD: begin
          slots[cnt[IDX_W-1:0]] = '{ev: EV_END, ch: 8'h00, new_pos: marked};
          cnt = cnt + CNT_W'(1);
        end
        MODE_BLOCK_CMT: begin
          slots[cnt[IDX_W-1:0]] = '{ev: EV_OPEN_CMT, ch: 8'h00, new_pos: marked};
          cnt = cnt + CNT_W'(1);
        end
        MODE_QUOTE: begin
          slots[cnt[IDX_W-1:0]] = '{ev: EV_OPEN_QUOTE, ch: 8'h00, new_pos: marked};
          cnt = cnt + CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    start_line_next = marked ? line_number : start_line;
    start_col_next  = marked ? column_number : start_column;
    line_next       = line_number;
    col_next        = column_number;
    if (byte_value == CH_NEWLINE) begin
      if (line_number != LINE_MAX) line_next = line_number + LINE_W'(1);
      col_next = COL_W'(1);
    end else if (column_number != COL_MAX) begin
      col_next = column_number + COL_W'(1);
    end
  end

  always_comb begin
    bundle.slots    = slots;
    bundle.cnt      = cnt;
    bundle.q        = (mode == MODE_QUOTE) || (mode_next == MODE_QUOTE);
    bundle.old_line = start_line;
    bundle.old_col  = start_column;
    bundle.cur_line = line_number;
    bundle.cur_col  = column_number;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_of_text)) begin
      mode          <= MODE_BETWEEN;
      star_seen     <= 1'b0;
      token_length  <= '0;
      line_number   <= LINE_W'(1);
      column_number <= COL_W'(1);
      start_line    <= LINE_W'(1);
      start_column  <= COL_W'(1);
    end else if (accept) begin
      mode          <= mode_next;
      star_seen     <= star_next;
      token_length  <= len_next;
      line_number   <= line_next;
      column_number <= col_next;
      start_line    <= start_line_next;
      start_column  <= start_col_next;
    end
  end

endmodule

/* rtl/stl_fifo.sv */
`timescale 1ns / 1ps
module stl_fifo import stl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t wr_data,
  output logic    full,
  input  logic    pop,
  output logic    q_valid,
  output bundle_t rd_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  bundle_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [PTR_W:0]   count;

  assign full    = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + PTR_W'(1);
      if (pop)  rptr <= rptr + PTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (PTR_W + 1)'(1);
        2'b01:   count <= count - (PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/stl_back.sv */
`timescale 1ns / 1ps
module stl_back import stl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  bundle_t           rd_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        event_res,
  output logic [7:0]        char_value,
  output logic [LINE_W-1:0] token_line,
  output logic [COL_W-1:0]  token_column,
  output logic              quoted,
  output logic              last_result
);

  bundle_t          cur;
  logic             cur_valid;
  logic [IDX_W-1:0] idx;
  slot_t            s;
  logic             at_last, take;

  assign s       = cur.slots[idx];
  assign at_last = ({1'b0, idx} + CNT_W'(1)) == cur.cnt;
  assign take    = cur_valid && !out_stall;
  // next bundle loads in the same cycle its predecessor's final beat goes out
  assign pop     = q_valid && (!cur_valid || (take && at_last));

  assign out_valid    = cur_valid;
  assign event_res    = s.ev;
  assign char_value   = s.ch;
  assign token_line   = s.new_pos ? cur.cur_line : cur.old_line;
  assign token_column = s.new_pos ? cur.cur_col : cur.old_col;
  assign quoted       = cur.q;
  assign last_result  = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (take) begin
      if (at_last) cur_valid <= 1'b0;
      else idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= rd_data;
  end

endmodule

/* rtl/script_token_lexer_top.sv */
// Script token lexer: one text byte in per beat, token events out.
// Input channel: in_valid / in_stall with byte_value and last_of_text.
//   A byte is taken on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with event_res, char_value,
//   token_line, token_column, quoted and last_result. One result per beat.
// Each byte yields zero to four results; last_result marks the final one.
// Throughput: one byte per cycle while each byte yields at most one result
//   and out_stall is low. The front lexer runs ahead through a four-entry
//   queue of per-byte results, so bytes that yield no result (whitespace,
//   comments) keep flowing while the output drains, until the queue fills.
// A byte's results pass through a queue entry, then the output register.
// When the receiver stalls, the output beat holds; once the queue fills,
//   in_stall rises.
// Reset (rst, synchronous) empties the queue and returns the lexer to line 1,
//   column 1, between tokens. A byte with last_of_text set returns the lexer
//   to that state once its results are queued; the queue is not emptied.
`timescale 1ns / 1ps
module script_token_lexer_top import stl_pkg::*; #(
  parameter int TOKEN_BUFFER_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        byte_value,
  input  logic              last_of_text,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        event_res,
  output logic [7:0]        char_value,
  output logic [LINE_W-1:0] token_line,
  output logic [COL_W-1:0]  token_column,
  output logic              quoted,
  output logic              last_result
);

  logic    push, full, pop, q_valid;
  bundle_t wr_data, rd_data;

  stl_front #(
    .TOKEN_BUFFER_BYTES(TOKEN_BUFFER_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_value   (byte_value),
    .last_of_text (last_of_text),
    .full         (full),
    .push         (push),
    .bundle       (wr_data)
  );

  stl_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_data),
    .full    (full),
    .pop     (pop),
    .q_valid (q_valid),
    .rd_data (rd_data)
  );

  stl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .rd_data      (rd_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .char_value   (char_value),
    .token_line   (token_line),
    .token_column (token_column),
    .quoted       (quoted),
    .last_result  (last_result)
  );

endmodule
